[rtl/core/bedar_pkg.sv]
package bedar_pkg;

  localparam int MASK_W = 18;
  localparam int BTN_IDX_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 1'd1;

  localparam logic [15:0] REPEAT_DELAY_RESET = 16'd300;
  localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd100;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_ABS = 16'd3;

  localparam logic [15:0] HAT_X_CODE = 16'h0010;
  localparam logic [15:0] HAT_Y_CODE = 16'h0011;

  localparam logic [15:0] CODE_A = 16'd304;
  localparam logic [15:0] CODE_B = 16'd305;
  localparam logic [15:0] CODE_X = 16'd307;
  localparam logic [15:0] CODE_Y = 16'd308;
  localparam logic [15:0] CODE_L1 = 16'd310;
  localparam logic [15:0] CODE_R1 = 16'd311;
  localparam logic [15:0] CODE_L2 = 16'd312;
  localparam logic [15:0] CODE_R2 = 16'd313;
  localparam logic [15:0] CODE_SELECT = 16'd314;
  localparam logic [15:0] CODE_START = 16'd315;
  localparam logic [15:0] CODE_MENU = 16'd316;
  localparam logic [15:0] CODE_POWER = 16'd116;
  localparam logic [15:0] CODE_PLUS = 16'd115;
  localparam logic [15:0] CODE_MINUS = 16'd114;

  localparam logic [BTN_IDX_W-1:0] POS_A = 5'd0;
  localparam logic [BTN_IDX_W-1:0] POS_B = 5'd1;
  localparam logic [BTN_IDX_W-1:0] POS_X = 5'd2;
  localparam logic [BTN_IDX_W-1:0] POS_Y = 5'd3;
  localparam logic [BTN_IDX_W-1:0] POS_L1 = 5'd4;
  localparam logic [BTN_IDX_W-1:0] POS_R1 = 5'd5;
  localparam logic [BTN_IDX_W-1:0] POS_L2 = 5'd6;
  localparam logic [BTN_IDX_W-1:0] POS_R2 = 5'd7;
  localparam logic [BTN_IDX_W-1:0] POS_SELECT = 5'd8;
  localparam logic [BTN_IDX_W-1:0] POS_START = 5'd9;
  localparam logic [BTN_IDX_W-1:0] POS_MENU = 5'd10;
  localparam logic [BTN_IDX_W-1:0] POS_POWER = 5'd11;
  localparam logic [BTN_IDX_W-1:0] POS_PLUS = 5'd12;
  localparam logic [BTN_IDX_W-1:0] POS_MINUS = 5'd13;
  localparam logic [BTN_IDX_W-1:0] POS_UP = 5'd14;
  localparam logic [BTN_IDX_W-1:0] POS_DOWN = 5'd15;
  localparam logic [BTN_IDX_W-1:0] POS_LEFT = 5'd16;
  localparam logic [BTN_IDX_W-1:0] POS_RIGHT = 5'd17;

  typedef struct packed {
    logic op;
    logic [31:0] now_ms;
    logic [15:0] event_type;
    logic [15:0] event_code;
    logic signed [31:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] pressed_mask;
    logic [MASK_W-1:0] released_mask;
    logic [MASK_W-1:0] repeated_mask;
  } out_item_t;

  typedef struct packed {
    logic hit;
    logic [BTN_IDX_W-1:0] idx;
  } key_hit_t;

  function automatic key_hit_t key_lookup(input logic [15:0] code);
    key_hit_t r;
    r.hit = 1'b1;
    r.idx = POS_A;
    unique case (code)
      CODE_A: r.idx = POS_A;
      CODE_B: r.idx = POS_B;
      CODE_X: r.idx = POS_X;
      CODE_Y: r.idx = POS_Y;
      CODE_L1: r.idx = POS_L1;
      CODE_R1: r.idx = POS_R1;
      CODE_L2: r.idx = POS_L2;
      CODE_R2: r.idx = POS_R2;
      CODE_SELECT: r.idx = POS_SELECT;
      CODE_START: r.idx = POS_START;
      CODE_MENU: r.idx = POS_MENU;
      CODE_POWER: r.idx = POS_POWER;
      CODE_PLUS: r.idx = POS_PLUS;
      CODE_MINUS: r.idx = POS_MINUS;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/button_event_decoder_autorepeat_core.sv]
// Button event decoder with auto repeat. Each transfer on the input channel is either a poll
// start (op 0), which latches now_ms, clears the pressed, released and repeated masks and flags
// every held button whose due time has passed, or a raw key or hat-axis event (op 1). Every
// input transfer yields exactly one output transfer with the four button masks. An item is
// held in the input register and is decoded and applied to the button state in one pass
// on its way to the output register, so one item is taken every cycle while the output is
// not stalled; its result is offered on the output once it has passed the input and output
// registers. All per-button due checks run in parallel, one 32-bit compare and add per button.
// The configuration port is always ready; write it only while no item is in flight.
module button_event_decoder_autorepeat_core #(
  parameter int NUM_BUTTONS = 18
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  bedar_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output bedar_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [bedar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] repeat_delay;
  logic [15:0] repeat_interval;

  logic s1_valid;
  bedar_pkg::in_item_t s1_data;
  logic advance;

  logic [NUM_BUTTONS-1:0] held_bits, held_bits_next;
  logic [NUM_BUTTONS-1:0] new_press_bits, new_press_bits_next;
  logic [NUM_BUTTONS-1:0] release_bits, release_bits_next;
  logic [NUM_BUTTONS-1:0] repeat_bits, repeat_bits_next;
  logic [31:0] repeat_due [NUM_BUTTONS];
  logic [31:0] repeat_due_next [NUM_BUTTONS];
  logic [31:0] poll_time, poll_time_next;

  logic [31:0] press_due;
  logic ev_neg;
  logic ev_zero;
  bedar_pkg::key_hit_t key_hit;
  logic press_req;
  logic [bedar_pkg::BTN_IDX_W-1:0] press_idx;
  logic [NUM_BUTTONS-1:0] press_vec;
  logic [NUM_BUTTONS-1:0] new_vec;
  logic [NUM_BUTTONS-1:0] release_vec;
  logic [NUM_BUTTONS-1:0] due_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay <= bedar_pkg::REPEAT_DELAY_RESET;
      repeat_interval <= bedar_pkg::REPEAT_INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bedar_pkg::CFG_REPEAT_DELAY: repeat_delay <= cfg_data;
        bedar_pkg::CFG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // event decode
  assign ev_neg = s1_data.event_value[31];
  assign ev_zero = (s1_data.event_value == 32'sd0);
  assign key_hit = bedar_pkg::key_lookup(s1_data.event_code);
  assign press_due = poll_time + {16'd0, repeat_delay};

  always_comb begin
    press_req = 1'b0;
    press_idx = bedar_pkg::POS_A;
    release_vec = '0;
    if (s1_data.event_type == bedar_pkg::EV_KEY) begin
      if (key_hit.hit && (ev_neg || ev_zero || s1_data.event_value == 32'sd1)) begin
        if (ev_zero) begin
          release_vec[key_hit.idx] = 1'b1;
        end else begin
          press_req = 1'b1;
          press_idx = key_hit.idx;
        end
      end
    end else if (s1_data.event_type == bedar_pkg::EV_ABS) begin
      if (s1_data.event_code == bedar_pkg::HAT_X_CODE) begin
        if (ev_zero) begin
          release_vec[bedar_pkg::POS_LEFT] = 1'b1;
          release_vec[bedar_pkg::POS_RIGHT] = 1'b1;
        end else begin
          press_req = 1'b1;
          press_idx = ev_neg ? bedar_pkg::POS_LEFT : bedar_pkg::POS_RIGHT;
        end
      end else if (s1_data.event_code == bedar_pkg::HAT_Y_CODE) begin
        if (ev_zero) begin
          release_vec[bedar_pkg::POS_UP] = 1'b1;
          release_vec[bedar_pkg::POS_DOWN] = 1'b1;
        end else begin
          press_req = 1'b1;
          press_idx = ev_neg ? bedar_pkg::POS_UP : bedar_pkg::POS_DOWN;
        end
      end
    end
  end

  assign press_vec = press_req ? ({{(NUM_BUTTONS-1){1'b0}}, 1'b1} << press_idx) : '0;
  assign new_vec = press_vec & ~held_bits;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      due_hit[i] = held_bits[i] && (s1_data.now_ms >= repeat_due[i]);
    end
  end

  always_comb begin
    held_bits_next = held_bits;
    new_press_bits_next = new_press_bits;
    release_bits_next = release_bits;
    repeat_bits_next = repeat_bits;
    poll_time_next = poll_time;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      repeat_due_next[i] = repeat_due[i];
    end
    if (s1_data.op == bedar_pkg::OP_POLL) begin
      poll_time_next = s1_data.now_ms;
      new_press_bits_next = '0;
      release_bits_next = '0;
      repeat_bits_next = due_hit;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (due_hit[i]) begin
          repeat_due_next[i] = repeat_due[i] + {16'd0, repeat_interval};
        end
      end
    end else begin
      held_bits_next = (held_bits | new_vec) & ~release_vec;
      new_press_bits_next = new_press_bits | new_vec;
      release_bits_next = release_bits | release_vec;
      repeat_bits_next = (repeat_bits | new_vec) & ~release_vec;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (new_vec[i]) begin
          repeat_due_next[i] = press_due;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bits <= '0;
      new_press_bits <= '0;
      release_bits <= '0;
      repeat_bits <= '0;
      poll_time <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        repeat_due[i] <= '0;
      end
    end else if (advance) begin
      held_bits <= held_bits_next;
      new_press_bits <= new_press_bits_next;
      release_bits <= release_bits_next;
      repeat_bits <= repeat_bits_next;
      poll_time <= poll_time_next;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        repeat_due[i] <= repeat_due_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.held_mask <= held_bits_next[bedar_pkg::MASK_W-1:0];
      out_data.pressed_mask <= new_press_bits_next[bedar_pkg::MASK_W-1:0];
      out_data.released_mask <= release_bits_next[bedar_pkg::MASK_W-1:0];
      out_data.repeated_mask <= repeat_bits_next[bedar_pkg::MASK_W-1:0];
    end
  end

endmodule

[test/button_event_decoder_autorepeat_core_test.sv]
`timescale 1ns / 1ps

module button_event_decoder_autorepeat_core_test;
  import bedar_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  button_event_decoder_autorepeat_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted button state
  logic [MASK_W-1:0] held_now = '0;
  logic [MASK_W-1:0] pressed_now = '0;
  logic [MASK_W-1:0] released_now = '0;
  logic [MASK_W-1:0] repeated_now = '0;
  logic [31:0] due_at [MASK_W];
  logic [31:0] poll_time = '0;
  logic [15:0] delay_ms = REPEAT_DELAY_RESET;
  logic [15:0] interval_ms = REPEAT_INTERVAL_RESET;
  out_item_t expected_masks [$];

  logic [31:0] sim_clock = '0;
  int burst_left = 0;
  bit steady_sender = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  int mismatches = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < MASK_W; i++) due_at[i] = '0;
  end

  function automatic int key_bit(input logic [15:0] code);
    case (code)
      CODE_A: return int'(POS_A);
      CODE_B: return int'(POS_B);
      CODE_X: return int'(POS_X);
      CODE_Y: return int'(POS_Y);
      CODE_L1: return int'(POS_L1);
      CODE_R1: return int'(POS_R1);
      CODE_L2: return int'(POS_L2);
      CODE_R2: return int'(POS_R2);
      CODE_SELECT: return int'(POS_SELECT);
      CODE_START: return int'(POS_START);
      CODE_MENU: return int'(POS_MENU);
      CODE_POWER: return int'(POS_POWER);
      CODE_PLUS: return int'(POS_PLUS);
      CODE_MINUS: return int'(POS_MINUS);
      default: return -1;
    endcase
  endfunction

  task automatic release_buttons(input logic [MASK_W-1:0] bits);
    held_now = held_now & ~bits;
    repeated_now = repeated_now & ~bits;
    released_now = released_now | bits;
  endtask

  task automatic press_button(input int idx);
    if (!held_now[idx]) begin
      pressed_now[idx] = 1'b1;
      repeated_now[idx] = 1'b1;
      held_now[idx] = 1'b1;
      due_at[idx] = poll_time + 32'(delay_ms);
    end
  endtask

  task automatic update_buttons(input in_item_t item);
    logic neg;
    logic zero;
    int idx;
    out_item_t res;
    neg = item.event_value[31];
    zero = (item.event_value == 32'd0);
    if (item.op == OP_POLL) begin
      poll_time = item.now_ms;
      pressed_now = '0;
      released_now = '0;
      repeated_now = '0;
      for (int i = 0; i < MASK_W; i++) begin
        if (held_now[i] && poll_time >= due_at[i]) begin
          repeated_now[i] = 1'b1;
          due_at[i] = due_at[i] + 32'(interval_ms);
        end
      end
    end else if (item.event_type == EV_KEY) begin
      idx = key_bit(item.event_code);
      if ((neg || item.event_value[30:0] <= 31'd1) && idx >= 0) begin
        if (zero) release_buttons(MASK_W'(1) << idx);
        else press_button(idx);
      end
    end else if (item.event_type == EV_ABS) begin
      if (item.event_code == HAT_X_CODE) begin
        if (zero) release_buttons((MASK_W'(1) << POS_LEFT) | (MASK_W'(1) << POS_RIGHT));
        else press_button(neg ? int'(POS_LEFT) : int'(POS_RIGHT));
      end else if (item.event_code == HAT_Y_CODE) begin
        if (zero) release_buttons((MASK_W'(1) << POS_UP) | (MASK_W'(1) << POS_DOWN));
        else press_button(neg ? int'(POS_UP) : int'(POS_DOWN));
      end
    end
    res.held_mask = held_now;
    res.pressed_mask = pressed_now;
    res.released_mask = released_now;
    res.repeated_mask = repeated_now;
    expected_masks.push_back(res);
  endtask

  // Keep in_valid high across a burst; lower it only for a gap.
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady_sender ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    update_buttons(item);
  endtask

  function automatic in_item_t poll_item(input logic [31:0] now);
    in_item_t item;
    item.op = OP_POLL;
    item.now_ms = now;
    item.event_type = 16'($urandom);
    item.event_code = 16'($urandom);
    item.event_value = $urandom;
    return item;
  endfunction

  function automatic in_item_t event_item(input logic [15:0] kind, input logic [15:0] code,
                                          input logic [31:0] value);
    in_item_t item;
    item.op = OP_EVENT;
    item.now_ms = $urandom;
    item.event_type = kind;
    item.event_code = code;
    item.event_value = value;
    return item;
  endfunction

  function automatic logic [15:0] pick_key_code();
    case ($urandom_range(0, 13))
      0: return CODE_A;
      1: return CODE_B;
      2: return CODE_X;
      3: return CODE_Y;
      4: return CODE_L1;
      5: return CODE_R1;
      6: return CODE_L2;
      7: return CODE_R2;
      8: return CODE_SELECT;
      9: return CODE_START;
      10: return CODE_MENU;
      11: return CODE_POWER;
      12: return CODE_PLUS;
      default: return CODE_MINUS;
    endcase
  endfunction

  function automatic in_item_t random_item();
    int r;
    logic [31:0] value;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: sim_clock = sim_clock + $urandom_range(0, 60);
        6, 7: sim_clock = sim_clock + $urandom_range(0, int'(delay_ms) + int'(interval_ms));
        8: sim_clock = $urandom;
        default: sim_clock = 32'hFFFF_FFFF - $urandom_range(0, 500);
      endcase
      return poll_item(sim_clock);
    end
    if (r < 65) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: value = 32'd0;
        4, 5, 6: value = 32'd1;
        7: value = {1'b1, 31'($urandom)};
        8: value = {1'b0, 31'($urandom_range(2, 1000))};
        default: value = $urandom;
      endcase
      return event_item(EV_KEY, pick_key_code(), value);
    end
    if (r < 88) begin
      case ($urandom_range(0, 4))
        0, 1: value = 32'd0;
        2: value = {1'b1, 31'($urandom)};
        default: value = {1'b0, 31'($urandom)} | 32'd1;
      endcase
      return event_item(EV_ABS, $urandom_range(0, 1) ? HAT_X_CODE : HAT_Y_CODE, value);
    end
    case ($urandom_range(0, 2))
      0: return event_item(EV_KEY, 16'($urandom), $urandom);
      1: return event_item(EV_ABS, 16'($urandom), $urandom);
      default: return event_item(16'($urandom), 16'($urandom), $urandom);
    endcase
  endfunction

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_masks.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_registers(input logic [15:0] delay, input logic [15:0] interval);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_REPEAT_DELAY;
    cfg_data <= delay;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    delay_ms = delay;
    cfg_index <= CFG_REPEAT_INTERVAL;
    cfg_data <= interval;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    interval_ms = interval;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_key_events();
    send_item(event_item(EV_KEY, CODE_A, 32'd1));
    send_item(event_item(EV_KEY, CODE_A, 32'd1));
    send_item(event_item(EV_KEY, CODE_B, 32'd2));
    send_item(event_item(EV_KEY, CODE_B, 32'h7FFF_FFFF));
    send_item(event_item(EV_KEY, CODE_MINUS, 32'h8000_0000));
    send_item(event_item(EV_KEY, CODE_X, 32'd0));
    send_item(event_item(EV_KEY, 16'd306, 32'd1));
    send_item(event_item(16'hFFFF, CODE_A, 32'd0));
    send_item(event_item(EV_KEY, CODE_A, 32'd0));
    send_item(event_item(EV_KEY, CODE_POWER, 32'd1));
    send_item(event_item(EV_KEY, CODE_PLUS, 32'hFFFF_FFFF));
  endtask

  task automatic test_hat_axes();
    send_item(event_item(EV_ABS, HAT_X_CODE, 32'hFFFF_FFFF));
    send_item(event_item(EV_ABS, HAT_X_CODE, 32'd5));
    send_item(event_item(EV_ABS, HAT_X_CODE, 32'd0));
    send_item(event_item(EV_ABS, HAT_Y_CODE, 32'd0));
    send_item(event_item(EV_ABS, HAT_Y_CODE, 32'h8000_0000));
    send_item(event_item(EV_ABS, HAT_Y_CODE, 32'h7FFF_FFFF));
    send_item(event_item(EV_ABS, 16'd0, 32'd1));
  endtask

  task automatic test_autorepeat_and_wrap();
    send_item(poll_item(32'd0));
    send_item(poll_item(32'd299));
    send_item(poll_item(32'd300));
    send_item(poll_item(32'hFFFF_FFFF));
    send_item(poll_item(32'hFFFF_FF00));
    send_item(event_item(EV_KEY, CODE_A, 32'd1));
    send_item(poll_item(32'hFFFF_FF01));
  endtask

  task automatic test_register_extremes();
    wait_for_idle();
    write_registers(16'd0, 16'd0);
    send_item(poll_item(32'd5000));
    send_item(event_item(EV_KEY, CODE_Y, 32'd1));
    send_item(poll_item(32'd5000));
    send_item(poll_item(32'd5000));
    wait_for_idle();
    write_registers(16'hFFFF, 16'hFFFF);
    send_item(poll_item(32'd10));
    send_item(event_item(EV_KEY, CODE_L1, 32'd1));
    send_item(poll_item(32'd65544));
    send_item(poll_item(32'd65545));
    send_item(poll_item(32'd131080));
  endtask

  task automatic test_backpressure();
    steady_sender = 1'b1;
    hold_request = 1'b1;
    repeat (60) send_item(random_item());
    steady_sender = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [15:0] delay;
    logic [15:0] interval;
    sim_clock = poll_time;
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_idle();
      case (phase)
        0: begin
          delay = REPEAT_DELAY_RESET;
          interval = REPEAT_INTERVAL_RESET;
        end
        1: begin
          delay = 16'd0;
          interval = 16'($urandom_range(0, 3));
        end
        default: begin
          delay = 16'($urandom_range(0, 400));
          interval = 16'($urandom_range(0, 200));
        end
      endcase
      write_registers(delay, interval);
      steady_sender = (phase % 3 == 2);
      repeat (180) send_item(random_item());
      if (phase == 3) test_backpressure();
    end
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    stall_phase++;
    if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= (stall_phase % 5 < 2);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_masks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %h", $realtime, out_data);
      end else begin
        want = expected_masks.pop_front();
        if (out_data.held_mask !== want.held_mask
            || out_data.pressed_mask !== want.pressed_mask
            || out_data.released_mask !== want.released_mask
            || out_data.repeated_mask !== want.repeated_mask) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: held %h/%h pressed %h/%h released %h/%h repeated %h/%h (exp/act)",
                     $realtime, want.held_mask, out_data.held_mask, want.pressed_mask,
                     out_data.pressed_mask, want.released_mask, out_data.released_mask,
                     want.repeated_mask, out_data.repeated_mask);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("button_event_decoder_autorepeat_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_key_events();
    test_hat_axes();
    test_autorepeat_and_wrap();
    test_register_extremes();
    test_random_traffic();
    wait_for_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_masks.size() == 0) begin
      $display("button_event_decoder_autorepeat_core test passed");
    end else begin
      $display("button_event_decoder_autorepeat_core test failed");
    end
    $finish;
  end

endmodule
